@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent checks clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/occ_pkg.sv @@
// ----------------------------------------------------------------------------
// occ_pkg
// Formats, coefficient codes and direction tables of the cone classifier.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned COMP_W    = 16;
    localparam int unsigned IDX_W     = 5;

    // Signed product of a component and the sqrt(1/2) coefficient.
    localparam int unsigned PROD_W = COMP_W + FRAC_BITS + 2;
    // Sum of three terms plus headroom.
    localparam int unsigned DOT_W  = PROD_W + 2;

    localparam int unsigned DIR_N   = 6;
    localparam int unsigned SEG_N   = 26;
    localparam int unsigned GRP_W   = 8;
    localparam int unsigned GRP_N   = 4;
    localparam int unsigned GRP_SEL = 3;
    localparam int unsigned HIT_W   = GRP_W * GRP_N;

    // sqrt(1/2) rounded to FRAC_BITS fraction bits.
    localparam logic [63:0] RT_SEED = 64'hB504_F333_F9DE_6484;
    localparam logic [63:0] RT_WIDE = ((RT_SEED >> (63 - FRAC_BITS)) + 64'd1) >> 1;
    localparam logic signed [FRAC_BITS+1:0] Q_RT = RT_WIDE[FRAC_BITS+1:0];

    localparam logic [COMP_W-1:0] COS_RESET = RT_WIDE[COMP_W-1:0];

    // Coefficient codes for one axis of a table vector.
    localparam logic [2:0] C_ZERO  = 3'd0;
    localparam logic [2:0] C_ONE   = 3'd1;
    localparam logic [2:0] C_NONE  = 3'd2;
    localparam logic [2:0] C_HALF  = 3'd3;
    localparam logic [2:0] C_NHALF = 3'd4;
    localparam logic [2:0] C_RT    = 3'd5;
    localparam logic [2:0] C_NRT   = 3'd6;

    typedef logic [2:0] coef_t;
    typedef coef_t vec_t [3];

    localparam vec_t DIR_TAB [DIR_N] = '{
        '{C_ONE,  C_ZERO, C_ZERO}, '{C_NONE, C_ZERO, C_ZERO},
        '{C_ZERO, C_ONE,  C_ZERO}, '{C_ZERO, C_NONE, C_ZERO},
        '{C_ZERO, C_ZERO, C_ONE},  '{C_ZERO, C_ZERO, C_NONE}
    };

    localparam vec_t SEG_TAB [SEG_N] = '{
        '{C_RT,    C_ZERO,  C_RT}, '{C_HALF,  C_HALF,  C_RT},
        '{C_ZERO,  C_RT,    C_RT}, '{C_NHALF, C_HALF,  C_RT},
        '{C_NRT,   C_ZERO,  C_RT}, '{C_NHALF, C_NHALF, C_RT},
        '{C_ZERO,  C_NRT,   C_RT}, '{C_HALF,  C_NHALF, C_RT},
        '{C_ONE,   C_ZERO,  C_ZERO}, '{C_RT,   C_RT,   C_ZERO},
        '{C_ZERO,  C_ONE,   C_ZERO}, '{C_NRT,  C_RT,   C_ZERO},
        '{C_NONE,  C_ZERO,  C_ZERO}, '{C_NRT,  C_NRT,  C_ZERO},
        '{C_ZERO,  C_NONE,  C_ZERO}, '{C_RT,   C_NRT,  C_ZERO},
        '{C_RT,    C_ZERO,  C_NRT}, '{C_HALF,  C_HALF,  C_NRT},
        '{C_ZERO,  C_RT,    C_NRT}, '{C_NHALF, C_HALF,  C_NRT},
        '{C_NRT,   C_ZERO,  C_NRT}, '{C_NHALF, C_NHALF, C_NRT},
        '{C_ZERO,  C_NRT,   C_NRT}, '{C_HALF,  C_NHALF, C_NRT},
        '{C_ZERO,  C_ZERO,  C_ONE},
        '{C_ZERO,  C_ZERO,  C_NONE}
    };

    // One term of a dot product: component scaled by a table coefficient.
    function automatic logic signed [DOT_W-1:0] axis_term(
        input coef_t                     code,
        input logic signed [COMP_W-1:0]  v,
        input logic signed [PROD_W-1:0]  vrt
    );
        logic signed [DOT_W-1:0] ve;
        logic signed [DOT_W-1:0] re;
        logic signed [DOT_W-1:0] res;
        begin
            ve = {{(DOT_W-COMP_W){v[COMP_W-1]}}, v};
            re = {{(DOT_W-PROD_W){vrt[PROD_W-1]}}, vrt};
            case (code)
                C_ONE:   res = ve <<< FRAC_BITS;
                C_NONE:  res = -(ve <<< FRAC_BITS);
                C_HALF:  res = ve <<< (FRAC_BITS - 1);
                C_NHALF: res = -(ve <<< (FRAC_BITS - 1));
                C_RT:    res = re;
                C_NRT:   res = -re;
                default: res = '0;
            endcase
            return res;
        end
    endfunction

endpackage

@@ hdl/orientation_cone_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// orientation_cone_classifier_unit
// Classifies an orientation vector against a fixed set of cone directions.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | operation, x_component, y_component,
//          |                      | z_component
//  out     | out_valid / out_stall| region_index, matched
//  cfg     | cfg_wr_en            | cfg_wr_data (cos_threshold)
//
// Four register stages: constant products, dot compares, group encode, final
// index. One transaction is taken every cycle unless a full pipeline stalls.
// Each stage holds its item only while the one after it is full and stalled,
// so bubbles are squeezed out and a stall loses nothing.
// Reset clears all valid bits and loads the threshold with cos 45 degrees.
`include "assert_macros.svh"

module orientation_cone_classifier_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [occ_pkg::COMP_W-1:0]   x_component,
    input  logic signed [occ_pkg::COMP_W-1:0]   y_component,
    input  logic signed [occ_pkg::COMP_W-1:0]   z_component,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [occ_pkg::IDX_W-1:0]           region_index,
    output logic                                matched,
    input  logic                                cfg_wr_en,
    input  logic signed [occ_pkg::COMP_W-1:0]   cfg_wr_data
);

    localparam int unsigned CW = occ_pkg::COMP_W;
    localparam int unsigned PW = occ_pkg::PROD_W;
    localparam int unsigned DW = occ_pkg::DOT_W;
    localparam int unsigned HW = occ_pkg::HIT_W;
    localparam int unsigned GN = occ_pkg::GRP_N;
    localparam int unsigned GW = occ_pkg::GRP_W;
    localparam int unsigned GS = occ_pkg::GRP_SEL;
    localparam int unsigned IW = occ_pkg::IDX_W;
    localparam logic [IW-1:0] DIR_NULL = IW'(occ_pkg::DIR_N);
    localparam logic [IW-1:0] SEG_NULL = IW'(occ_pkg::SEG_N);

    logic signed [CW-1:0] cos_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic                 op1_reg;
    logic signed [CW-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [PW-1:0] xrt1_reg, yrt1_reg, zrt1_reg;

    logic          op2_reg;
    logic [HW-1:0] hit2_reg;
    logic [HW-1:0] hit_next;

    logic          op3_reg;
    logic [GN-1:0] gany3_reg;
    logic [GS-1:0] gidx3_reg [GN];
    logic [GN-1:0] gany_next;
    logic [GS-1:0] gidx_next [GN];

    logic [IW-1:0] idx4_reg;
    logic          match4_reg;
    logic [IW-1:0] idx_next;
    logic          match_next;

    // A stage loads when it is empty or its item moves on in this cycle.
    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= signed'(occ_pkg::COS_RESET);
        end
        else if (cfg_wr_en)
        begin
            cos_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: capture components and their sqrt(1/2) products.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg  <= operation;
            x1_reg   <= x_component;
            y1_reg   <= y_component;
            z1_reg   <= z_component;
            xrt1_reg <= PW'(x_component) * PW'(occ_pkg::Q_RT);
            yrt1_reg <= PW'(y_component) * PW'(occ_pkg::Q_RT);
            zrt1_reg <= PW'(z_component) * PW'(occ_pkg::Q_RT);
        end
    end

    // Stage 2: every dot product of the chosen table against the threshold scaled to its format.
    always_comb
    begin
        logic signed [DW-1:0] limit;
        logic signed [DW-1:0] dot;
        limit = {{(DW-CW){cos_reg[CW-1]}}, cos_reg} <<< occ_pkg::FRAC_BITS;
        hit_next = '0;
        if (op1_reg)
        begin
            for (int i = 0; i < occ_pkg::SEG_N; i++)
            begin
                dot = occ_pkg::axis_term(occ_pkg::SEG_TAB[i][0], x1_reg, xrt1_reg)
                    + occ_pkg::axis_term(occ_pkg::SEG_TAB[i][1], y1_reg, yrt1_reg)
                    + occ_pkg::axis_term(occ_pkg::SEG_TAB[i][2], z1_reg, zrt1_reg);
                hit_next[i] = dot > limit;
            end
        end
        else
        begin
            for (int i = 0; i < occ_pkg::DIR_N; i++)
            begin
                dot = occ_pkg::axis_term(occ_pkg::DIR_TAB[i][0], x1_reg, xrt1_reg)
                    + occ_pkg::axis_term(occ_pkg::DIR_TAB[i][1], y1_reg, yrt1_reg)
                    + occ_pkg::axis_term(occ_pkg::DIR_TAB[i][2], z1_reg, zrt1_reg);
                hit_next[i] = dot > limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            op2_reg  <= op1_reg;
            hit2_reg <= hit_next;
        end
    end

    // Stage 3: first hit inside each group of eight.
    always_comb
    begin
        for (int g = 0; g < GN; g++)
        begin
            gany_next[g] = |hit2_reg[g*GW +: GW];
            gidx_next[g] = '0;
            for (int b = GW - 1; b >= 0; b--)
            begin
                if (hit2_reg[g*GW + b])
                begin
                    gidx_next[g] = GS'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            op3_reg   <= op2_reg;
            gany3_reg <= gany_next;
            for (int g = 0; g < GN; g++)
            begin
                gidx3_reg[g] <= gidx_next[g];
            end
        end
    end

    // Stage 4: first group with a hit, or the null index of the chosen set.
    always_comb
    begin
        idx_next   = op3_reg ? SEG_NULL : DIR_NULL;
        match_next = |gany3_reg;
        for (int g = GN - 1; g >= 0; g--)
        begin
            if (gany3_reg[g])
            begin
                idx_next = IW'(g * GW) | IW'(gidx3_reg[g]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            idx4_reg   <= idx_next;
            match4_reg <= match_next;
        end
    end

    assign out_valid    = v4_reg;
    assign region_index = idx4_reg;
    assign matched      = match4_reg;

    `ASSERT_IMPLY(a_null_index, out_valid && !matched,
        region_index == DIR_NULL || region_index == SEG_NULL,
        "unmatched result without a null index")
    `ASSERT_IMPLY(a_match_range, out_valid && matched, region_index < SEG_NULL,
        "matched result with an index beyond the table")
    `ASSERT_ALWAYS(a_stall_full, !in_stall || (v1_reg && v2_reg && v3_reg && v4_reg),
        "input stalled while a pipeline stage is empty")

endmodule

@@ tb/cone_region_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cone_region_checker
// Watches the input, output and threshold ports of the cone classifier.
// Predicts the region of each accepted vector from its own direction tables
// and compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module cone_region_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic signed [occ_pkg::COMP_W-1:0]   x_component,
    input  logic signed [occ_pkg::COMP_W-1:0]   y_component,
    input  logic signed [occ_pkg::COMP_W-1:0]   z_component,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [occ_pkg::IDX_W-1:0]           region_index,
    input  logic                                matched,
    input  logic                                cfg_wr_en,
    input  logic signed [occ_pkg::COMP_W-1:0]   cfg_wr_data,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic [occ_pkg::IDX_W-1:0] region;
        logic                      hit;
    } region_result_t;

    localparam longint UNIT = 64'sd1 << occ_pkg::FRAC_BITS;
    localparam longint HALF = 64'sd1 << (occ_pkg::FRAC_BITS - 1);
    // sqrt(1/2) rounded to the nearest step of the fixed-point format.
    localparam longint DIAG = 64'sd11585;

    localparam logic signed [occ_pkg::COMP_W-1:0] THRESHOLD_AT_RESET = 16'sd11585;

    localparam longint DIR_X [6] = '{UNIT, -UNIT, 0, 0, 0, 0};
    localparam longint DIR_Y [6] = '{0, 0, UNIT, -UNIT, 0, 0};
    localparam longint DIR_Z [6] = '{0, 0, 0, 0, UNIT, -UNIT};

    // Upper ring, horizon ring, lower ring (eight azimuths each), then up and down.
    localparam longint SEG_X [26] = '{
        DIAG, HALF, 0, -HALF, -DIAG, -HALF, 0, HALF,
        UNIT, DIAG, 0, -DIAG, -UNIT, -DIAG, 0, DIAG,
        DIAG, HALF, 0, -HALF, -DIAG, -HALF, 0, HALF,
        0, 0};
    localparam longint SEG_Y [26] = '{
        0, HALF, DIAG, HALF, 0, -HALF, -DIAG, -HALF,
        0, DIAG, UNIT, DIAG, 0, -DIAG, -UNIT, -DIAG,
        0, HALF, DIAG, HALF, 0, -HALF, -DIAG, -HALF,
        0, 0};
    localparam longint SEG_Z [26] = '{
        DIAG, DIAG, DIAG, DIAG, DIAG, DIAG, DIAG, DIAG,
        0, 0, 0, 0, 0, 0, 0, 0,
        -DIAG, -DIAG, -DIAG, -DIAG, -DIAG, -DIAG, -DIAG, -DIAG,
        UNIT, -UNIT};

    logic signed [occ_pkg::COMP_W-1:0] cos_threshold;
    region_result_t                    expected_regions [$];

    // First table vector whose dot product lies strictly above the scaled
    // threshold; the table size stands for no match.
    function automatic region_result_t predict_region(
        input logic                              op,
        input logic signed [occ_pkg::COMP_W-1:0] x,
        input logic signed [occ_pkg::COMP_W-1:0] y,
        input logic signed [occ_pkg::COMP_W-1:0] z,
        input logic signed [occ_pkg::COMP_W-1:0] thr
    );
        longint         limit;
        longint         dot;
        int             count;
        int             i;
        region_result_t r;
        begin
            limit = longint'(thr) * UNIT;
            count = op ? occ_pkg::SEG_N : occ_pkg::DIR_N;
            r.region = occ_pkg::IDX_W'(count);
            r.hit = 1'b0;
            for (i = 0; i < count; i++)
            begin
                if (op)
                    dot = longint'(x) * SEG_X[i] + longint'(y) * SEG_Y[i]
                        + longint'(z) * SEG_Z[i];
                else
                    dot = longint'(x) * DIR_X[i] + longint'(y) * DIR_Y[i]
                        + longint'(z) * DIR_Z[i];
                if (!r.hit && dot > limit)
                begin
                    r.region = occ_pkg::IDX_W'(i);
                    r.hit = 1'b1;
                end
            end
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        region_result_t want;
        if (!rst_n)
        begin
            cos_threshold = THRESHOLD_AT_RESET;
            expected_regions.delete();
            fail_count = 0;
        end
        else
        begin
            // Results are registered and leave later than their vector, so the
            // output side is served before this edge's input transaction.
            if (out_valid && !out_stall)
            begin
                if (expected_regions.size() == 0)
                begin
                    $error("result transaction with nothing expected: region_index %0d matched %0d",
                           region_index, matched);
                    fail_count++;
                end
                else
                begin
                    want = expected_regions.pop_front();
                    if (region_index !== want.region)
                    begin
                        $error("region_index: expected %0d, got %0d", want.region, region_index);
                        fail_count++;
                    end
                    if (matched !== want.hit)
                    begin
                        $error("matched: expected %0d, got %0d", want.hit, matched);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_regions.insert(expected_regions.size(),
                                        predict_region(operation, x_component,
                                                       y_component, z_component,
                                                       cos_threshold));
            if (cfg_wr_en)
                cos_threshold = cfg_wr_data;
        end
        pending = expected_regions.size();
    end

endmodule

@@ tb/tb_orientation_cone_classifier_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_orientation_cone_classifier_unit
// Drives orientation vectors and threshold settings into the cone classifier
// under three idling patterns; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_orientation_cone_classifier_unit;

    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int RANDOM_PER_SETTING = 44;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                operation;
    logic signed [occ_pkg::COMP_W-1:0]   x_component;
    logic signed [occ_pkg::COMP_W-1:0]   y_component;
    logic signed [occ_pkg::COMP_W-1:0]   z_component;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [occ_pkg::IDX_W-1:0]           region_index;
    logic                                matched;
    logic                                cfg_wr_en;
    logic signed [occ_pkg::COMP_W-1:0]   cfg_wr_data;

    int                                  fail_count;
    int                                  pending;
    int                                  send_idle_pct = 15;
    int                                  recv_idle_pct = 75;
    logic signed [occ_pkg::COMP_W-1:0]   current_threshold = 16'sd11585;

    orientation_cone_classifier_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .x_component  (x_component),
        .y_component  (y_component),
        .z_component  (z_component),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .region_index (region_index),
        .matched      (matched),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    cone_region_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .x_component  (x_component),
        .y_component  (y_component),
        .z_component  (z_component),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .region_index (region_index),
        .matched      (matched),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Ends the run when no transaction moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_vector(
        input logic                              op,
        input logic signed [occ_pkg::COMP_W-1:0] x,
        input logic signed [occ_pkg::COMP_W-1:0] y,
        input logic signed [occ_pkg::COMP_W-1:0] z
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        x_component <= x;
        y_component <= y;
        z_component <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The pipeline is drained before the threshold changes.
    task automatic write_threshold(input logic signed [occ_pkg::COMP_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (6) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        current_threshold = value;
    endtask

    // Components that land on or next to the comparison boundary.
    function automatic logic signed [occ_pkg::COMP_W-1:0] boundary_component();
        case ($urandom_range(0, 7))
            0: return 16'sd0;
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd8192;
            4: return 16'sd11585;
            5: return current_threshold;
            6: return current_threshold + 16'sd1;
            default: return -current_threshold;
        endcase
    endfunction

    task automatic pick_vector(
        output logic signed [occ_pkg::COMP_W-1:0] x,
        output logic signed [occ_pkg::COMP_W-1:0] y,
        output logic signed [occ_pkg::COMP_W-1:0] z
    );
        int  kind;
        real rx;
        real ry;
        real rz;
        real norm;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            rx = real'(int'($urandom_range(0, 2000)) - 1000);
            ry = real'(int'($urandom_range(0, 2000)) - 1000);
            rz = real'(int'($urandom_range(0, 2000)) - 1000);
            norm = $sqrt(rx * rx + ry * ry + rz * rz);
            if (norm < 1.0)
            begin
                rx = 1.0;
                ry = 0.0;
                rz = 0.0;
                norm = 1.0;
            end
            x = 16'(int'(rx / norm * 16384.0));
            y = 16'(int'(ry / norm * 16384.0));
            z = 16'(int'(rz / norm * 16384.0));
        end
        else if (kind < 7)
        begin
            x = boundary_component();
            y = boundary_component();
            z = boundary_component();
        end
        else
        begin
            x = 16'($urandom());
            y = 16'($urandom());
            z = 16'($urandom());
        end
    endtask

    initial
    begin
        logic signed [occ_pkg::COMP_W-1:0] vx;
        logic signed [occ_pkg::COMP_W-1:0] vy;
        logic signed [occ_pkg::COMP_W-1:0] vz;
        logic signed [occ_pkg::COMP_W-1:0] settings [8];
        int                                mode;
        int                                k;
        int                                n;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = 1'b0;
        x_component = '0;
        y_component = '0;
        z_component = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors at the reset threshold: every axis in both sets,
        // the zero vector, full-scale components and the strict boundary.
        send_vector(1'b0,  16'sd16384, 16'sd0, 16'sd0);
        send_vector(1'b0, -16'sd16384, 16'sd0, 16'sd0);
        send_vector(1'b0, 16'sd0,  16'sd16384, 16'sd0);
        send_vector(1'b0, 16'sd0, -16'sd16384, 16'sd0);
        send_vector(1'b0, 16'sd0, 16'sd0,  16'sd16384);
        send_vector(1'b0, 16'sd0, 16'sd0, -16'sd16384);
        send_vector(1'b1,  16'sd16384, 16'sd0, 16'sd0);
        send_vector(1'b1, -16'sd16384, 16'sd0, 16'sd0);
        send_vector(1'b1, 16'sd0,  16'sd16384, 16'sd0);
        send_vector(1'b1, 16'sd0, -16'sd16384, 16'sd0);
        send_vector(1'b1, 16'sd0, 16'sd0,  16'sd16384);
        send_vector(1'b1, 16'sd0, 16'sd0, -16'sd16384);
        send_vector(1'b0, 16'sd0, 16'sd0, 16'sd0);
        send_vector(1'b1, 16'sd0, 16'sd0, 16'sd0);
        send_vector(1'b0, 16'sd11585, 16'sd0, 16'sd0);
        send_vector(1'b0, 16'sd11586, 16'sd0, 16'sd0);
        send_vector(1'b1, 16'sd11585, 16'sd0, 16'sd11585);
        send_vector(1'b1, -16'sd11585, -16'sd11585, 16'sd0);
        send_vector(1'b1, 16'sd8192, -16'sd8192, -16'sd11585);
        send_vector(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
        send_vector(1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
        send_vector(1'b1, 16'sd32767, -16'sd32768, 16'sd0);

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 75;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            settings = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, 16'sd8192,
                         16'sd32767, -16'sd32768,
                         16'(int'($urandom_range(0, 32768)) - 16384)};
            for (k = 0; k < 8; k++)
            begin
                write_threshold(settings[k]);
                for (n = 0; n < RANDOM_PER_SETTING; n++)
                begin
                    pick_vector(vx, vy, vz);
                    send_vector(1'($urandom_range(0, 1)), vx, vy, vz);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/occ_pkg.sv
hdl/orientation_cone_classifier_unit.sv
tb/cone_region_checker.sv
tb/tb_orientation_cone_classifier_unit.sv
